FILE: hdl/rle8_pkg.sv
// shared types and constants of the rle8 run decoder
`timescale 1ns / 1ps
`default_nettype none

package rle8_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    localparam int CFG_W    = 13;
    localparam int COLUMN_W = 16;
    localparam int ROW_W    = 13;
    localparam int OUT_POS_W = 12;

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam int CMD_FIFO_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_RUN,
        OP_EOL,
        OP_EOB,
        OP_DELTA,
        OP_LIT
    } cmd_op_t;

    // one classified item handed from the front to the back
    typedef struct packed {
        cmd_op_t    op;
        logic       start;
        logic       last;
        logic [7:0] arg_a;  // run count or column delta
        logic [7:0] arg_b;  // pixel value or row delta
    } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/rle8_front.sv
// byte parser: tracks the escape phase and turns each byte into a command
`timescale 1ns / 1ps
`default_nettype none

module rle8_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire logic          frame_start,
    input  wire logic [7:0]    stream_byte,
    input  wire logic          stream_last,
    output rle8_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_VALUE,
        PH_DX,
        PH_DY,
        PH_ABS,
        PH_PAD
    } phase_t;

    phase_t     phase_reg, phase_next, phase_base;
    logic [7:0] held_count_reg, held_count_next, held_count_base;
    logic [7:0] held_dx_reg, held_dx_next, held_dx_base;
    logic [7:0] abs_left_reg, abs_left_next, abs_left_base;
    logic       pad_reg, pad_next, pad_base;

    always_comb
    begin
        // a new frame clears the phase before this byte is looked at
        phase_base      = frame_start ? PH_COUNT : phase_reg;
        held_count_base = frame_start ? 8'd0 : held_count_reg;
        held_dx_base    = frame_start ? 8'd0 : held_dx_reg;
        abs_left_base   = frame_start ? 8'd0 : abs_left_reg;
        pad_base        = frame_start ? 1'b0 : pad_reg;

        phase_next      = phase_base;
        held_count_next = held_count_base;
        held_dx_next    = held_dx_base;
        abs_left_next   = abs_left_base;
        pad_next        = pad_base;

        cmd.op    = rle8_pkg::OP_NOP;
        cmd.start = frame_start;
        cmd.last  = stream_last;
        cmd.arg_a = 8'd0;
        cmd.arg_b = stream_byte;

        unique case (phase_base)
            PH_COUNT:
            begin
                held_count_next = stream_byte;
                phase_next      = PH_VALUE;
            end
            PH_VALUE:
            begin
                phase_next = PH_COUNT;
                if (held_count_base != 8'd0)
                begin
                    cmd.op    = rle8_pkg::OP_RUN;
                    cmd.arg_a = held_count_base;
                end
                else if (stream_byte == 8'd0)
                begin
                    cmd.op = rle8_pkg::OP_EOL;
                end
                else if (stream_byte == 8'd1)
                begin
                    cmd.op = rle8_pkg::OP_EOB;
                end
                else if (stream_byte == 8'd2)
                begin
                    phase_next = PH_DX;
                end
                else
                begin
                    abs_left_next = stream_byte;
                    pad_next      = stream_byte[0];
                    phase_next    = PH_ABS;
                end
            end
            PH_DX:
            begin
                held_dx_next = stream_byte;
                phase_next   = PH_DY;
            end
            PH_DY:
            begin
                cmd.op     = rle8_pkg::OP_DELTA;
                cmd.arg_a  = held_dx_base;
                phase_next = PH_COUNT;
            end
            PH_ABS:
            begin
                cmd.op = rle8_pkg::OP_LIT;
                if (abs_left_base != 8'd0)
                begin
                    abs_left_next = abs_left_base - 8'd1;
                end
                if (abs_left_next == 8'd0)
                begin
                    phase_next = pad_base ? PH_PAD : PH_COUNT;
                end
            end
            PH_PAD:
            begin
                // odd literal runs carry one filler byte
                phase_next = PH_COUNT;
            end
            default:
            begin
                phase_next = PH_COUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_COUNT;
            held_count_reg <= 8'd0;
            held_dx_reg    <= 8'd0;
            abs_left_reg   <= 8'd0;
            pad_reg        <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            held_count_reg <= held_count_next;
            held_dx_reg    <= held_dx_next;
            abs_left_reg   <= abs_left_next;
            pad_reg        <= pad_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rle8_cmd_fifo.sv
// small command queue between parser and run generator
`timescale 1ns / 1ps
`default_nettype none

module rle8_cmd_fifo
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire rle8_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output rle8_pkg::cmd_t     pop_data,
    output logic               empty
);

    localparam int DEPTH = rle8_pkg::CMD_FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rle8_pkg::cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rle8_back.sv
// run generator: keeps the plane position and forms one result per command
`timescale 1ns / 1ps
`default_nettype none

module rle8_back
#(
    parameter int MAX_WIDTH  = rle8_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = rle8_pkg::DEFAULT_MAX_HEIGHT
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [rle8_pkg::CFG_W-1:0]        image_width,
    input  wire logic [rle8_pkg::CFG_W-1:0]        image_height,
    input  wire logic                              cmd_empty,
    input  wire rle8_pkg::cmd_t                    cmd,
    output logic                                   cmd_pop,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   write_valid,
    output logic [rle8_pkg::OUT_POS_W-1:0]         write_row,
    output logic [rle8_pkg::OUT_POS_W-1:0]         write_column,
    output logic [7:0]                             write_value,
    output logic [7:0]                             write_length,
    output logic                                   finished
);

    localparam int CW = rle8_pkg::CFG_W;
    localparam int COLW = rle8_pkg::COLUMN_W;
    localparam int RW = rle8_pkg::ROW_W;
    localparam int PW = rle8_pkg::OUT_POS_W;

    logic [COLW-1:0] column_reg, column_next, column_base;
    logic [RW-1:0]   row_reg, row_next, row_base;
    logic            done_reg, done_next, done_base;

    logic            out_valid_reg;
    logic            wv_next, fin_next;
    logic [PW-1:0]   wr_next, wc_next;
    logic [7:0]      wval_next, wlen_next;

    logic [CW-1:0]   w_eff, h_eff;
    logic            col_inside;
    logic [CW-1:0]   room;
    logic [7:0]      run_len;
    logic [COLW:0]   col_sum;
    logic [RW:0]     row_sum;

    // effective plane size is the register capped by the build limit
    assign w_eff = ({4'd0, image_width} < 17'(MAX_WIDTH)) ? image_width : CW'(MAX_WIDTH);
    assign h_eff = ({4'd0, image_height} < 17'(MAX_HEIGHT)) ? image_height : CW'(MAX_HEIGHT);

    assign cmd_pop   = !cmd_empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        column_base = cmd.start ? '0 : column_reg;
        row_base    = cmd.start ? '0 : row_reg;
        done_base   = cmd.start ? 1'b0 : done_reg;

        col_inside = {{(COLW - CW){1'b0}}, w_eff} > column_base;
        room       = w_eff - column_base[CW-1:0];
        run_len    = ({5'd0, cmd.arg_a} < room) ? cmd.arg_a : room[7:0];
        col_sum    = {1'b0, column_base} + (COLW + 1)'(cmd.arg_a);
        row_sum    = {1'b0, row_base} + (RW + 1)'(cmd.arg_b);

        column_next = column_base;
        row_next    = row_base;
        done_next   = done_base;
        wv_next     = 1'b0;
        wr_next     = '0;
        wc_next     = '0;
        wval_next   = '0;
        wlen_next   = '0;
        fin_next    = 1'b0;

        if (!done_base && row_base >= h_eff)
        begin
            done_next = 1'b1;
            fin_next  = 1'b1;
        end
        else if (!done_base)
        begin
            unique case (cmd.op)
                rle8_pkg::OP_RUN:
                begin
                    if (col_inside)
                    begin
                        wv_next     = 1'b1;
                        wr_next     = row_base[PW-1:0];
                        wc_next     = column_base[PW-1:0];
                        wval_next   = cmd.arg_b;
                        wlen_next   = run_len;
                        column_next = column_base + COLW'(run_len);
                    end
                end
                rle8_pkg::OP_LIT:
                begin
                    if (col_inside)
                    begin
                        wv_next     = 1'b1;
                        wr_next     = row_base[PW-1:0];
                        wc_next     = column_base[PW-1:0];
                        wval_next   = cmd.arg_b;
                        wlen_next   = 8'd1;
                        column_next = column_base + 1'b1;
                    end
                end
                rle8_pkg::OP_EOL:
                begin
                    // row is below the height here, so the increment cannot wrap
                    column_next = '0;
                    row_next    = row_base + 1'b1;
                    if (row_next >= h_eff)
                    begin
                        done_next = 1'b1;
                        fin_next  = 1'b1;
                    end
                end
                rle8_pkg::OP_EOB:
                begin
                    done_next = 1'b1;
                    fin_next  = 1'b1;
                end
                rle8_pkg::OP_DELTA:
                begin
                    // both coordinates saturate
                    column_next = col_sum[COLW] ? '1 : col_sum[COLW-1:0];
                    row_next    = row_sum[RW] ? '1 : row_sum[RW-1:0];
                    if (row_next >= h_eff)
                    begin
                        done_next = 1'b1;
                        fin_next  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (cmd.last && !done_next)
            begin
                done_next = 1'b1;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                column_reg    <= column_next;
                row_reg       <= row_next;
                done_reg      <= done_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            write_valid  <= wv_next;
            write_row    <= wr_next;
            write_column <= wc_next;
            write_value  <= wval_next;
            write_length <= wlen_next;
            finished     <= fin_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rle8_run_decoder_unit.sv
// top level of the rle8 run decoder
//
// Takes one compressed RLE8 byte per item and returns exactly one result item
// for it: a run write (row, column, value, length) when write_valid is high,
// and finished high on the item with which decoding ends. Sustained rate is
// one item per cycle while out_stall stays low. The parser forms its command
// combinationally and writes the two-entry queue at the accepting edge; the run
// generator pops an item into the output register once that register is
// free or being taken. While a result waits under out_stall the queue fills
// its two entries before in_stall rises. Register 0 is the image width,
// register 1 the image height, both 13 bits, reset to 1; write them only
// while no item is in flight. Set frame_start on the first byte of each image.
`timescale 1ns / 1ps
`default_nettype none

module rle8_run_decoder_unit
#(
    parameter int MAX_WIDTH  = rle8_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = rle8_pkg::DEFAULT_MAX_HEIGHT
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_enable,
    input  wire logic                              cfg_index,
    input  wire logic [rle8_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              frame_start,
    input  wire logic [7:0]                        stream_byte,
    input  wire logic                              stream_last,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   write_valid,
    output logic [rle8_pkg::OUT_POS_W-1:0]         write_row,
    output logic [rle8_pkg::OUT_POS_W-1:0]         write_column,
    output logic [7:0]                             write_value,
    output logic [7:0]                             write_length,
    output logic                                   finished
);

    logic [rle8_pkg::CFG_W-1:0] image_width_reg, image_height_reg;

    rle8_pkg::cmd_t front_cmd, back_cmd;
    logic           in_fire, q_full, q_empty, q_pop;

    assign in_stall = q_full;
    assign in_fire  = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= rle8_pkg::CFG_W'(1);
            image_height_reg <= rle8_pkg::CFG_W'(1);
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                rle8_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                rle8_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rle8_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (in_fire),
        .frame_start (frame_start),
        .stream_byte (stream_byte),
        .stream_last (stream_last),
        .cmd         (front_cmd)
    );

    rle8_cmd_fifo u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (back_cmd),
        .empty     (q_empty)
    );

    rle8_back
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .cmd_empty    (q_empty),
        .cmd          (back_cmd),
        .cmd_pop      (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_valid  (write_valid),
        .write_row    (write_row),
        .write_column (write_column),
        .write_value  (write_value),
        .write_length (write_length),
        .finished     (finished)
    );

endmodule

`default_nettype wire

FILE: hdl/rle8_checker.sv
// port-level checks on the rle8 run decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module rle8_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        write_valid,
    input  wire logic [11:0] write_row,
    input  wire logic [11:0] write_column,
    input  wire logic [7:0]  write_value,
    input  wire logic [7:0]  write_length
);

    // a held result keeps its valid flag, row, column and length
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(write_valid)
            && $stable(write_row) && $stable(write_column)
            && $stable(write_length))
        else $error("result changed while stalled");

    // an item without a write carries zero fields
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_valid |-> write_row == 12'd0 && write_column == 12'd0
            && write_value == 8'd0 && write_length == 8'd0)
        else $error("non-zero fields on an item without a write");

    // a write always covers at least one pixel
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_valid |-> write_length != 8'd0)
        else $error("zero-length run write");

    // nothing comes out in the cycle after reset is released
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present straight after reset");

endmodule

bind rle8_run_decoder_unit rle8_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_valid  (write_valid),
    .write_row    (write_row),
    .write_column (write_column),
    .write_value  (write_value),
    .write_length (write_length)
);

`default_nettype wire

FILE: dv/tb_rle8_run_decoder_unit.sv
// self-checking testbench of the rle8 run decoder unit
`timescale 1ns / 1ps

module tb_rle8_run_decoder_unit;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 1000;
    localparam int MAX_REPORTS   = 10;
    localparam int ITEM_TARGET   = 1800;
    localparam int MAX_W         = rle8_pkg::DEFAULT_MAX_WIDTH;
    localparam int MAX_H         = rle8_pkg::DEFAULT_MAX_HEIGHT;
    localparam int COLUMN_MAX    = 65535;
    localparam int ROW_MAX       = 8191;
    localparam int PHASE_COUNT   = 10;
    localparam int SWEEP_DELTAS  = 258;
    localparam int PW            = rle8_pkg::OUT_POS_W;
    localparam int CW            = rle8_pkg::CFG_W;

    // count byte that opens an escape, and the escape codes after it
    localparam logic [7:0] ESC_MARK  = 8'd0;
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_VALUE,
        PH_DX,
        PH_DY,
        PH_LITERAL,
        PH_PAD
    } decode_phase_t;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
        logic       last;
    } stream_item_t;

    typedef struct packed {
        logic          wr_valid;
        logic [PW-1:0] row;
        logic [PW-1:0] column;
        logic [7:0]    value;
        logic [7:0]    length;
        logic          fin;
    } run_write_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_write_enable = 1'b0;
    logic             cfg_index = rle8_pkg::CFG_IMAGE_WIDTH;
    logic [CW-1:0]    cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             frame_start = 1'b0;
    logic [7:0]       stream_byte = 8'd0;
    logic             stream_last = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             write_valid;
    logic [PW-1:0]    write_row;
    logic [PW-1:0]    write_column;
    logic [7:0]       write_value;
    logic [7:0]       write_length;
    logic             finished;

    stream_item_t pending_bytes[$];
    run_write_t   expected_writes[$];

    // decoder copy: sizes and position state
    int            size_width;
    int            size_height;
    decode_phase_t dec_phase;
    int            dec_column;
    int            dec_row;
    int            dec_count;
    int            dec_dx;
    int            dec_lit_left;
    logic          dec_pad;
    logic          dec_done;

    int   mismatches = 0;
    int   idle_cycles = 0;
    int   queued_total = 0;
    logic take_next = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   run_left = 1;
    int   stall_left = 0;

    int phase_width [PHASE_COUNT] = '{16, 1, 4096, 200, 7, 0, 8191, 64, 40, 3};
    int phase_height[PHASE_COUNT] = '{8, 1, 4096, 3, 4095, 2, 8191, 0, 20, 4096};

    rle8_run_decoder_unit dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .frame_start      (frame_start),
        .stream_byte      (stream_byte),
        .stream_last      (stream_last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .write_valid      (write_valid),
        .write_row        (write_row),
        .write_column     (write_column),
        .write_value      (write_value),
        .write_length     (write_length),
        .finished         (finished)
    );

    always #CLK_HALF clk = ~clk;

    function automatic void clear_decoder();
        dec_phase    = PH_COUNT;
        dec_column   = 0;
        dec_row      = 0;
        dec_count    = 0;
        dec_dx       = 0;
        dec_lit_left = 0;
        dec_pad      = 1'b0;
        dec_done     = 1'b0;
    endfunction

    function automatic run_write_t decode_byte(logic start, logic [7:0] b, logic last);
        run_write_t res;
        int         w;
        int         h;
        int         len;
        res = '0;
        w = (size_width < MAX_W) ? size_width : MAX_W;
        h = (size_height < MAX_H) ? size_height : MAX_H;
        if (start)
            clear_decoder();
        if (!dec_done && dec_row >= h)
        begin
            dec_done = 1'b1;
            res.fin = 1'b1;
        end
        else if (!dec_done)
        begin
            case (dec_phase)
                PH_COUNT:
                begin
                    dec_count = b;
                    dec_phase = PH_VALUE;
                end
                PH_VALUE:
                begin
                    dec_phase = PH_COUNT;
                    if (dec_count != 0)
                    begin
                        // runs are clipped at the row end, none past it
                        if (dec_column < w)
                        begin
                            len = (dec_count < w - dec_column) ? dec_count : w - dec_column;
                            res.wr_valid = 1'b1;
                            res.row      = PW'(dec_row);
                            res.column   = PW'(dec_column);
                            res.value    = b;
                            res.length   = 8'(len);
                            dec_column   = dec_column + len;
                        end
                    end
                    else if (b == ESC_EOL)
                    begin
                        dec_column = 0;
                        dec_row    = dec_row + 1;
                        if (dec_row >= h)
                        begin
                            dec_done = 1'b1;
                            res.fin  = 1'b1;
                        end
                    end
                    else if (b == ESC_EOB)
                    begin
                        dec_done = 1'b1;
                        res.fin  = 1'b1;
                    end
                    else if (b == ESC_DELTA)
                        dec_phase = PH_DX;
                    else
                    begin
                        dec_lit_left = b;
                        dec_pad      = b[0];
                        dec_phase    = PH_LITERAL;
                    end
                end
                PH_DX:
                begin
                    dec_dx    = b;
                    dec_phase = PH_DY;
                end
                PH_DY:
                begin
                    dec_column = dec_column + dec_dx;
                    if (dec_column > COLUMN_MAX)
                        dec_column = COLUMN_MAX;
                    dec_row = dec_row + b;
                    if (dec_row > ROW_MAX)
                        dec_row = ROW_MAX;
                    dec_phase = PH_COUNT;
                    if (dec_row >= h)
                    begin
                        dec_done = 1'b1;
                        res.fin  = 1'b1;
                    end
                end
                PH_LITERAL:
                begin
                    if (dec_column < w)
                    begin
                        res.wr_valid = 1'b1;
                        res.row      = PW'(dec_row);
                        res.column   = PW'(dec_column);
                        res.value    = b;
                        res.length   = 8'd1;
                        dec_column   = dec_column + 1;
                    end
                    if (dec_lit_left > 0)
                        dec_lit_left = dec_lit_left - 1;
                    if (dec_lit_left == 0)
                        dec_phase = dec_pad ? PH_PAD : PH_COUNT;
                end
                default:
                    dec_phase = PH_COUNT;
            endcase
            if (last && !dec_done)
            begin
                dec_done = 1'b1;
                res.fin  = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic void push_byte(logic start, logic [7:0] b, logic last);
        stream_item_t item;
        item.start = start;
        item.data  = b;
        item.last  = last;
        pending_bytes.push_back(item);
        queued_total = queued_total + 1;
    endfunction

    // mostly small values, now and then anywhere up to the rare limit
    function automatic int pick_value(int lo, int hi_common, int hi_rare);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(hi_rare, lo);
        return $urandom_range(hi_common, lo);
    endfunction

    task automatic queue_frame(int n_cmds);
        int first;
        int sel;
        int n;
        int ending;
        first = pending_bytes.size();
        for (int c = 0; c < n_cmds; c++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                push_byte(1'b0, 8'(pick_value(1, 16, 255)), 1'b0);
                push_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            end
            else if (sel < 60)
            begin
                push_byte(1'b0, ESC_MARK, 1'b0);
                push_byte(1'b0, ESC_EOL, 1'b0);
            end
            else if (sel < 72)
            begin
                push_byte(1'b0, ESC_MARK, 1'b0);
                push_byte(1'b0, ESC_DELTA, 1'b0);
                push_byte(1'b0, 8'(pick_value(0, 7, 255)), 1'b0);
                n = $urandom_range(0, 99);
                push_byte(1'b0, 8'((n < 85) ? $urandom_range(0, 1) :
                                   (n < 95) ? $urandom_range(0, 3) :
                                   $urandom_range(0, 255)), 1'b0);
            end
            else if (sel < 94)
            begin
                n = pick_value(3, 8, 255);
                push_byte(1'b0, ESC_MARK, 1'b0);
                push_byte(1'b0, 8'(n), 1'b0);
                for (int k = 0; k < n + (n % 2); k++)
                    push_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            end
            else
                push_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0);
        end
        ending = $urandom_range(0, 9);
        if (ending < 4)
        begin
            push_byte(1'b0, ESC_MARK, 1'b0);
            push_byte(1'b0, ESC_EOB, 1'b0);
            // trailing bytes after the end marker are ignored
            for (int k = $urandom_range(0, 2); k > 0; k--)
                push_byte(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        else if (ending < 9)
        begin
            // a tail marked last that may cut a pair or delta short
            if (ending >= 7)
            begin
                push_byte(1'b0, ESC_MARK, 1'b0);
                if (ending == 8)
                begin
                    push_byte(1'b0, ESC_DELTA, 1'b0);
                    push_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0);
                end
            end
            if (pending_bytes.size() > first)
                pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        end
        if (pending_bytes.size() > first)
            pending_bytes[first].start = 1'b1;
    endtask

    task automatic write_sizes(int w, int h);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= rle8_pkg::CFG_IMAGE_WIDTH;
        cfg_data         <= CW'(w);
        @(negedge clk);
        cfg_index        <= rle8_pkg::CFG_IMAGE_HEIGHT;
        cfg_data         <= CW'(h);
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        size_width  = w % (1 << CW);
        size_height = h % (1 << CW);
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender: bursts of random length with random gaps between them
    always @(negedge clk)
    begin : sender
        if (rst_n && (!in_valid || take_next))
        begin
            take_next = 1'b0;
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                in_valid    <= 1'b1;
                frame_start <= pending_bytes[0].start;
                stream_byte <= pending_bytes[0].data;
                stream_last <= pending_bytes[0].last;
                if (burst_left > 1)
                    burst_left = burst_left - 1;
                else
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stalls on a pattern of its own
    always @(negedge clk)
    begin : receiver
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (run_left > 1)
                run_left = run_left - 1;
            else
            begin
                run_left   = $urandom_range(1, 40);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        run_write_t got;
        run_write_t want;
        logic       in_taken;
        logic       out_taken;
        if (rst_n)
        begin
            in_taken  = in_valid && !in_stall;
            out_taken = out_valid && !out_stall;
            if (in_taken)
            begin
                expected_writes.push_back(decode_byte(frame_start, stream_byte, stream_last));
                pending_bytes.delete(0);
                take_next = 1'b1;
            end
            if (out_taken)
            begin
                got.wr_valid = write_valid;
                got.row      = write_row;
                got.column   = write_column;
                got.value    = write_value;
                got.length   = write_length;
                got.fin      = finished;
                if (expected_writes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected item: v=%0d r=%0d c=%0d val=%0d len=%0d fin=%0d",
                                 got.wr_valid, got.row, got.column, got.value, got.length,
                                 got.fin);
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("mismatch, exp v=%0d r=%0d c=%0d val=%0d len=%0d fin=%0d",
                                     want.wr_valid, want.row, want.column, want.value,
                                     want.length, want.fin);
                            $display("mismatch, got v=%0d r=%0d c=%0d val=%0d len=%0d fin=%0d",
                                     got.wr_valid, got.row, got.column, got.value,
                                     got.length, got.fin);
                        end
                    end
                end
            end
            if (in_taken || out_taken)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_rle8_run_decoder_unit: FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int base;
        int queued;
        int per_phase;
        size_width  = 1;
        size_height = 1;
        clear_decoder();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_sizes(16, 8);
        push_byte(1'b1, 8'd5, 1'b0);
        push_byte(1'b0, 8'hAA, 1'b0);
        // clipped at the row end, then a run that starts past it
        push_byte(1'b0, 8'd255, 1'b0);
        push_byte(1'b0, 8'h55, 1'b0);
        push_byte(1'b0, ESC_MARK, 1'b0);
        push_byte(1'b0, ESC_DELTA, 1'b0);
        push_byte(1'b0, 8'd255, 1'b0);
        push_byte(1'b0, 8'd1, 1'b0);
        push_byte(1'b0, 8'd1, 1'b0);
        push_byte(1'b0, 8'hFF, 1'b0);
        // odd literal with pad, all of it past the width
        push_byte(1'b0, ESC_MARK, 1'b0);
        push_byte(1'b0, 8'd3, 1'b0);
        push_byte(1'b0, 8'h12, 1'b0);
        push_byte(1'b0, 8'h34, 1'b0);
        push_byte(1'b0, 8'h56, 1'b0);
        push_byte(1'b0, 8'hEE, 1'b0);
        push_byte(1'b0, ESC_MARK, 1'b0);
        push_byte(1'b0, ESC_EOB, 1'b0);
        push_byte(1'b0, 8'h42, 1'b0);
        // pair cut short by the final byte
        push_byte(1'b1, 8'd7, 1'b1);
        // delta that takes the row past the height
        push_byte(1'b1, ESC_MARK, 1'b0);
        push_byte(1'b0, ESC_DELTA, 1'b0);
        push_byte(1'b0, 8'd0, 1'b0);
        push_byte(1'b0, 8'd200, 1'b0);
        drain();

        // column saturation, then a lower height under an open frame
        write_sizes(16, 4096);
        push_byte(1'b1, ESC_MARK, 1'b0);
        push_byte(1'b0, ESC_DELTA, 1'b0);
        push_byte(1'b0, 8'd3, 1'b0);
        push_byte(1'b0, 8'd100, 1'b0);
        for (int k = 0; k < SWEEP_DELTAS; k++)
        begin
            push_byte(1'b0, ESC_MARK, 1'b0);
            push_byte(1'b0, ESC_DELTA, 1'b0);
            push_byte(1'b0, 8'd255, 1'b0);
            push_byte(1'b0, 8'd0, 1'b0);
        end
        push_byte(1'b0, 8'd2, 1'b0);
        push_byte(1'b0, 8'h09, 1'b0);
        drain();
        write_sizes(16, 50);
        push_byte(1'b0, 8'h33, 1'b0);
        drain();

        // the rest of the item budget is spread over the size phases
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_sizes(phase_width[p], phase_height[p]);
            per_phase = (ITEM_TARGET - queued_total) / (PHASE_COUNT - p);
            if (per_phase < 1)
                per_phase = 1;
            queued = 0;
            while (queued < per_phase)
            begin
                base = pending_bytes.size();
                queue_frame($urandom_range(2, 10));
                queued = queued + pending_bytes.size() - base;
            end
            drain();
        end

        if (mismatches == 0 && expected_writes.size() == 0)
            $display("tb_rle8_run_decoder_unit: PASS");
        else
            $display("tb_rle8_run_decoder_unit: FAIL");
        $finish;
    end

endmodule
